// File: design/isqrt_pkg.sv
// Shared constants and the working-word type for the integer square root.
// No dependencies; imported by isqrt_stage and integer_square_root_32.
`default_nettype none

package isqrt_pkg;

	// Recurrence steps, one pipeline stage each (legal range 1 to 16)
	localparam int STEPS = 16;

	// Field widths
	localparam int VALUE_W = 32;
	localparam int ROOT_W  = 16;
	localparam int WORK_W  = 18;

	// Working word carried from stage to stage
	typedef struct packed {
		logic [VALUE_W-1:0] num;
		logic [WORK_W-1:0]  rem;
		logic [WORK_W-1:0]  dbl;
	} isqrt_work_t;

endpackage

`default_nettype wire

// File: design/integer_square_root_32.sv
// Integer square root of a 32-bit unsigned radicand.
// Input channel: value with value_valid / value_ready; output channel: root with
// root_valid / root_ready. A beat moves when valid and ready are both high.
// The result is floor(sqrt(value)) as a 16-bit unsigned number.
// Each of the STEPS (16) recurrence steps is one registered pipeline stage.
// Throughput is one beat per cycle while root_ready is high: a new radicand may
// enter on every cycle while earlier ones are still moving through the stages.
// The cost of one stage is a single 18-bit compare and subtract.
// When the receiver holds root_ready low, the last stage holds its beat and
// the stall moves back stage by stage; empty stages still fill, so up to
// STEPS beats are held before value_ready falls. Nothing is lost or repeated.
// Reset (arst_n low, asynchronous) empties every stage; no beat is in flight
// afterwards and value_ready is high.
// Depends on isqrt_pkg and isqrt_stage.
`default_nettype none

module integer_square_root_32 import isqrt_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               value_valid,
	output logic                    value_ready,
	input  wire logic [VALUE_W-1:0] value,
	output logic                    root_valid,
	input  wire logic               root_ready,
	output logic [ROOT_W-1:0]       root
);

	logic        vld [STEPS+1];
	logic        rdy [STEPS+1];
	isqrt_work_t work [STEPS+1];

	// Seed the first stage with the radicand and a cleared remainder and root
	assign vld[0]      = value_valid;
	assign value_ready = rdy[0];
	assign work[0]     = '{num: value, rem: '0, dbl: '0};

	// Chain the recurrence stages
	for (genvar i = 0; i < STEPS; i++) begin : g_stage
		isqrt_stage u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_vld   (vld[i]),
			.in_rdy   (rdy[i]),
			.in_work  (work[i]),
			.out_vld  (vld[i+1]),
			.out_rdy  (rdy[i+1]),
			.out_work (work[i+1])
		);
	end

	// Drive the output beat: halve the doubled root
	assign rdy[STEPS]  = root_ready;
	assign root_valid  = vld[STEPS];
	assign root        = work[STEPS].dbl[ROOT_W:1];

endmodule

`default_nettype wire

// File: design/isqrt_stage.sv
// One step of the restoring digit-by-digit square root, registered, with handshake.
// Depends on isqrt_pkg for the working-word type and widths.
`default_nettype none

module isqrt_stage import isqrt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_vld,
	output logic             in_rdy,
	input  wire isqrt_work_t in_work,
	output logic             out_vld,
	input  wire logic        out_rdy,
	output isqrt_work_t      out_work
);

	logic        vld_s1;
	isqrt_work_t work_s1;
	isqrt_work_t step_work;
	logic [WORK_W-1:0] rem_sh;
	logic [WORK_W-1:0] dbl_sh;

	// Take a new beat when the register is empty or is being drained
	assign in_rdy = !vld_s1 || out_rdy;

	// Shift in the next two radicand bits, then trial-subtract the shifted doubled root plus one
	always_comb begin
		rem_sh = {in_work.rem[WORK_W-3:0], in_work.num[VALUE_W-1 -: 2]};
		dbl_sh = {in_work.dbl[WORK_W-2:0], 1'b0};
		step_work.num = {in_work.num[VALUE_W-3:0], 2'b00};
		step_work.rem = rem_sh;
		step_work.dbl = dbl_sh;
		if (dbl_sh < rem_sh) begin
			step_work.rem = rem_sh - dbl_sh - WORK_W'(1);
			step_work.dbl = dbl_sh + WORK_W'(2);
		end
	end

	// Advance the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_rdy) begin
			vld_s1 <= in_vld;
		end
	end

	// Load the payload on an accepted beat, hold it otherwise
	always_ff @(posedge clk) begin
		if (in_vld && in_rdy) begin
			work_s1 <= step_work;
		end
	end

	assign out_vld  = vld_s1;
	assign out_work = work_s1;

	// A stalled beat is neither dropped nor altered
	a_hold_vld: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld && !out_rdy |=> out_vld)
		else $error("isqrt_stage: stalled beat dropped");

	a_hold_work: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld && !out_rdy |=> $stable(out_work))
		else $error("isqrt_stage: stalled payload changed");

	// The doubled root is always even
	a_dbl_even: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld |-> !out_work.dbl[0])
		else $error("isqrt_stage: doubled root is odd");

endmodule

`default_nettype wire
